/* rtl/sbrp_pkg.sv */
package sbrp_pkg;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NODE  = 2'd1,
    OP_BEGIN = 2'd2
  } sbrp_op_e;

  // Configuration register indexes
  localparam logic CFG_NODE_COUNT    = 1'b0;
  localparam logic CFG_RETAIN_RADIUS = 1'b1;

  // Queue depths between the parts
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         node_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               cost_negative;
  } sbrp_in_t;

  typedef struct packed {
    logic       keep;
    logic [5:0] dest_slot;
    logic       stop;
    logic [6:0] kept_count;
  } sbrp_out_t;

  typedef struct packed {
    logic [4:0]  node_count;
    logic [30:0] retain_radius;
  } sbrp_cfg_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic is_begin;
    logic last;
    logic neg;
    logic in_range;
  } sbrp_task_t;

endpackage

/* rtl/sbrp_fifo.sv */
module sbrp_fifo #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/sbrp_front.sv */
module sbrp_front #(
  parameter int unsigned MAX_NODES  = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbrp_pkg::sbrp_cfg_t cfg_i,
  input  logic                push_i,
  input  sbrp_pkg::sbrp_in_t  item_i,
  output logic                full_o,
  output logic                task_push_o,
  output sbrp_pkg::sbrp_task_t task_o,
  input  logic                task_full_i
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned NW  = $clog2(MAX_NODES + 1);
  localparam int unsigned IXW = (NW > 5) ? NW : 5;
  localparam int unsigned AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // Reference store
  logic signed [CB-1:0] ref_x_q [MAX_NODES];
  logic signed [CB-1:0] ref_y_q [MAX_NODES];
  logic signed [CB-1:0] ref_z_q [MAX_NODES];

  // Pipeline valids and handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  // Item decode
  logic [IXW-1:0]       idx_ext, nc_ext, cnt;
  logic [AW-1:0]        addr;
  logic signed [CB-1:0] cx, cy, cz;
  logic                 is_load, is_node, is_begin, relevant, is_last;

  // Stage payloads
  logic                 b1_q, l1_q, n1_q;
  logic signed [CB-1:0] x1_q, y1_q, z1_q, rx1_q, ry1_q, rz1_q;
  logic                 b2_q, l2_q, n2_q;
  logic [CB-1:0]        ax2_q, ay2_q, az2_q;
  logic                 b3_q, l3_q, n3_q;
  logic [63:0]          sx3_q, sy3_q, sz3_q;
  logic                 b4_q, l4_q, n4_q, ovf4_q;
  logic [63:0]          sxy4_q, sz4_q;
  logic [61:0]          r2_q;

  logic [CB-1:0] ax, ay, az;
  logic [64:0]   sum_xy, sum_all;

  function automatic logic [CB-1:0] abs_diff(logic signed [CB-1:0] a,
                                             logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    d = (CB+1)'(a) - (CB+1)'(b);
    abs_diff = d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  // Back-pressure through the stages
  assign rdy4   = !v4_q || !task_full_i;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign full_o = !rdy1;
  assign accept = push_i && rdy1;

  // Classify the incoming item
  assign cx      = item_i.coord_x[CB-1:0];
  assign cy      = item_i.coord_y[CB-1:0];
  assign cz      = item_i.coord_z[CB-1:0];
  assign idx_ext = IXW'(item_i.node_index);
  assign nc_ext  = IXW'(cfg_i.node_count);
  assign cnt     = (nc_ext == '0) ? IXW'(1) :
                   (nc_ext > IXW'(MAX_NODES)) ? IXW'(MAX_NODES) : nc_ext;
  assign addr    = idx_ext[AW-1:0];

  always_comb begin
    is_load  = 1'b0;
    is_node  = 1'b0;
    is_begin = 1'b0;
    unique case (item_i.op)
      sbrp_pkg::OP_LOAD:  is_load  = (idx_ext < IXW'(MAX_NODES));
      sbrp_pkg::OP_NODE:  is_node  = (idx_ext < cnt);
      sbrp_pkg::OP_BEGIN: is_begin = 1'b1;
      default: ;
    endcase
  end

  assign relevant = is_node || is_begin;
  assign is_last  = (idx_ext == cnt - 1'b1);

  // Reference loads and registered reads
  always_ff @(posedge clk_i) begin
    if (accept && is_load) begin
      ref_x_q[addr] <= cx;
      ref_y_q[addr] <= cy;
      ref_z_q[addr] <= cz;
    end
    if (accept) begin
      rx1_q <= ref_x_q[addr];
      ry1_q <= ref_y_q[addr];
      rz1_q <= ref_z_q[addr];
      x1_q  <= cx;
      y1_q  <= cy;
      z1_q  <= cz;
      b1_q  <= is_begin;
      l1_q  <= is_last;
      n1_q  <= item_i.cost_negative;
    end
  end

  // Squared radius, held ready for the compare
  always_ff @(posedge clk_i) begin
    r2_q <= 62'(cfg_i.retain_radius) * 62'(cfg_i.retain_radius);
  end

  assign ax = abs_diff(x1_q, rx1_q);
  assign ay = abs_diff(y1_q, ry1_q);
  assign az = abs_diff(z1_q, rz1_q);

  // Distance pipeline payloads
  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      ax2_q <= ax;
      ay2_q <= ay;
      az2_q <= az;
      b2_q  <= b1_q;
      l2_q  <= l1_q;
      n2_q  <= n1_q;
    end
    if (v2_q && rdy3) begin
      sx3_q <= 64'(ax2_q) * 64'(ax2_q);
      sy3_q <= 64'(ay2_q) * 64'(ay2_q);
      sz3_q <= 64'(az2_q) * 64'(az2_q);
      b3_q  <= b2_q;
      l3_q  <= l2_q;
      n3_q  <= n2_q;
    end
    if (v3_q && rdy4) begin
      sxy4_q <= sum_xy[63:0];
      ovf4_q <= sum_xy[64];
      sz4_q  <= sz3_q;
      b4_q   <= b3_q;
      l4_q   <= l3_q;
      n4_q   <= n3_q;
    end
  end

  assign sum_xy = {1'b0, sx3_q} + {1'b0, sy3_q};

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept && relevant;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Final sum and radius compare on the way into the queue
  assign sum_all = {1'b0, sxy4_q} + {1'b0, sz4_q};

  assign task_push_o     = v4_q && !task_full_i;
  assign task_o.is_begin = b4_q;
  assign task_o.last     = l4_q;
  assign task_o.neg      = n4_q;
  assign task_o.in_range = !ovf4_q && !sum_all[64] && (sum_all[63:0] < 64'(r2_q));

endmodule

/* rtl/sbrp_back.sv */
module sbrp_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbrp_pkg::sbrp_task_t task_i,
  input  logic                 task_empty_i,
  output logic                 task_pop_o,
  output logic                 res_push_o,
  output sbrp_pkg::sbrp_out_t  res_o,
  input  logic                 res_full_i
);

  localparam int unsigned TW = $clog2(BUFFER_DEPTH + 1);

  logic          within_q, stopped_q;
  logic [TW-1:0] total_q;
  logic          produces, within_n, keep;
  logic [TW-1:0] total_n;

  // Decision for the head task
  assign produces = !task_i.is_begin && task_i.last && !stopped_q;
  assign within_n = within_q && task_i.in_range;
  assign keep     = within_n && (total_q < TW'(BUFFER_DEPTH));
  assign total_n  = keep ? total_q + 1'b1 : total_q;

  assign task_pop_o = !task_empty_i && (!produces || !res_full_i);
  assign res_push_o = !task_empty_i && produces && !res_full_i;

  assign res_o.keep       = keep;
  assign res_o.dest_slot  = keep ? 6'(total_q) : 6'd0;
  assign res_o.stop       = task_i.neg;
  assign res_o.kept_count = 7'(total_n);

  // Pass state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      within_q  <= 1'b1;
      stopped_q <= 1'b0;
      total_q   <= '0;
    end else if (task_pop_o) begin
      if (task_i.is_begin) begin
        within_q  <= 1'b1;
        stopped_q <= 1'b0;
        total_q   <= '0;
      end else if (!stopped_q) begin
        if (task_i.last) begin
          within_q  <= 1'b1;
          total_q   <= total_n;
          stopped_q <= task_i.neg;
        end else begin
          within_q  <= within_n;
        end
      end
    end
  end

endmodule

/* rtl/sample_buffer_radius_prune_core.sv */
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// input     in         push / full               in_item_i  (sbrp_in_t)
// result    out        empty / pop               out_item_o (sbrp_out_t)
// config    in         cfg_we_i, cfg_idx_i       cfg_data_i (31 bits, no wait)
//
// One item is taken every cycle unless full; the four-stage distance pipeline
// (read of the reference store, absolute differences, squares, partial sum) is
// fully pipelined. Each entry's result then passes the task and result queues.
// The reference store is not cleared at reset; nodes must be loaded before use.
// full rises only when the task queue and the distance pipeline are backed up.
module sample_buffer_radius_prune_core #(
  parameter int unsigned MAX_NODES    = 16,
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned COORD_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sbrp_pkg::sbrp_in_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output sbrp_pkg::sbrp_out_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [30:0]         cfg_data_i
);

  sbrp_pkg::sbrp_cfg_t  cfg_q;
  sbrp_pkg::sbrp_task_t task_wr, task_rd;
  sbrp_pkg::sbrp_out_t  res;
  logic                 task_push, task_full, task_empty, task_pop;
  logic                 res_push, res_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count    <= 5'd1;
      cfg_q.retain_radius <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbrp_pkg::CFG_NODE_COUNT:    cfg_q.node_count    <= cfg_data_i[4:0];
        sbrp_pkg::CFG_RETAIN_RADIUS: cfg_q.retain_radius <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbrp_front #(
    .MAX_NODES  (MAX_NODES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .task_push_o (task_push),
    .task_o      (task_wr),
    .task_full_i (task_full)
  );

  sbrp_fifo #(
    .WIDTH ($bits(sbrp_pkg::sbrp_task_t)),
    .DEPTH (sbrp_pkg::MID_DEPTH)
  ) u_task_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (task_push),
    .wdata_i (task_wr),
    .pop_i   (task_pop),
    .rdata_o (task_rd),
    .full_o  (task_full),
    .empty_o (task_empty)
  );

  sbrp_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (task_rd),
    .task_empty_i (task_empty),
    .task_pop_o   (task_pop),
    .res_push_o   (res_push),
    .res_o        (res),
    .res_full_i   (res_full)
  );

  sbrp_fifo #(
    .WIDTH ($bits(sbrp_pkg::sbrp_out_t)),
    .DEPTH (sbrp_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

endmodule

/* rtl/sbrp_checker.sv */
module sbrp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input sbrp_pkg::sbrp_out_t out_item_o
);

  // Nothing to deliver while held in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // A kept entry's slot sits just below the running count
  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.keep) |->
      (out_item_o.dest_slot == 6'(out_item_o.kept_count[5:0] - 6'd1)))
    else $error("dest_slot does not match kept_count");

  // A dropped entry carries no slot
  a_drop_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.keep) |-> (out_item_o.dest_slot == 6'd0))
    else $error("dropped entry with nonzero slot");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

endmodule

bind sample_buffer_radius_prune_core sbrp_checker u_sbrp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
